FILE: src/lfr_pkg.sv
// Package for the LEB128 and little-endian field reader.
// Holds field kinds, item and result types, and bit constants.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

  // Width of the byte cursor; it wraps at this width.
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned SHIFT_W     = 7;

  // Stream port widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = VALUE_W + 2 * COUNT_W;
  localparam int unsigned OUT_TUSER_W = 1;

  // Byte masks and the last usable bit of the accumulator.
  localparam logic [7:0] LOW7_MASK = 8'h7f;
  localparam logic [7:0] CONT_MASK = 8'h80;
  localparam logic [7:0] SIGN_MASK = 8'h40;
  localparam logic [SHIFT_W-1:0] LAST_BIT = 7'd63;

  // Field kinds, sampled from the opcode at the first byte of a field.
  typedef enum logic [2:0] {
    OP_U8      = 3'd0,
    OP_U16     = 3'd1,
    OP_U32     = 3'd2,
    OP_U64     = 3'd3,
    OP_ULEB    = 3'd4,
    OP_SLEB    = 3'd5,
    OP_STRING  = 3'd6,
    OP_RESTART = 3'd7
  } op_t;

  // One input item.
  typedef struct packed {
    op_t        opcode;
    logic [7:0] data_byte;
    logic       buffer_exhausted;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [VALUE_W-1:0] field_value;
    logic               all_ok;
    logic [COUNT_W-1:0] field_start;
    logic [COUNT_W-1:0] bytes_used;
  } result_t;

endpackage : lfr_pkg

`default_nettype wire

FILE: src/lfr_decode.sv
// Field decoder: holds the field state and folds one byte per step into it.
// The result of a step is combinational; the top level registers it.
// Depends on lfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfr_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire lfr_pkg::item_t   item,
  output logic                 res_valid,
  output lfr_pkg::result_t     res
);
  import lfr_pkg::*;

  op_t                    kind_r, kind_nxt;
  logic                   in_field_r, in_field_nxt;
  logic [VALUE_W-1:0]     acc_r, acc_nxt;
  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic                   ok_r, ok_nxt;
  logic [OFFSET_BITS-1:0] cursor_r, cursor_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;

  logic                   done;
  logic [VALUE_W-1:0]     value;
  logic [VALUE_W-1:0]     byte_ext;
  logic [VALUE_W-1:0]     low7_ext;
  logic [SHIFT_W-1:0]     limit;

  // Next state and result of one byte.
  always_comb begin
    kind_nxt     = kind_r;
    in_field_nxt = in_field_r;
    acc_nxt      = acc_r;
    shift_nxt    = shift_r;
    ok_nxt       = ok_r;
    cursor_nxt   = cursor_r;
    start_nxt    = start_r;
    done         = 1'b0;
    value        = '0;
    byte_ext     = {{(VALUE_W-8){1'b0}}, item.data_byte};
    low7_ext     = {{(VALUE_W-8){1'b0}}, item.data_byte & LOW7_MASK};
    limit        = '0;

    if (!in_field_r && item.opcode == OP_RESTART) begin
      // A restart outside a field resets the cursor and marks the run bad.
      ok_nxt     = 1'b0;
      cursor_nxt = '0;
    end else begin
      // Open a new field on its first byte.
      if (!in_field_r) begin
        kind_nxt     = item.opcode;
        start_nxt    = cursor_r;
        acc_nxt      = '0;
        shift_nxt    = '0;
        in_field_nxt = 1'b1;
      end

      if (item.buffer_exhausted) begin
        // Out of bytes: end the field with a zero value.
        ok_nxt  = 1'b0;
        acc_nxt = '0;
        done    = 1'b1;
        value   = '0;
      end else begin
        cursor_nxt = cursor_r + OFFSET_BITS'(1);
        case (kind_nxt)
          OP_U8, OP_U16, OP_U32, OP_U64: begin
            acc_nxt   = acc_nxt | (byte_ext << shift_nxt[5:0]);
            limit     = SHIFT_W'(7'd8 << kind_nxt[1:0]);
            shift_nxt = shift_nxt + SHIFT_W'(8);
            done      = (shift_nxt >= limit);
            value     = acc_nxt;
          end
          OP_ULEB: begin
            acc_nxt = acc_nxt | (low7_ext << shift_nxt[5:0]);
            value   = acc_nxt;
            if ((item.data_byte & CONT_MASK) == 8'h00) begin
              done = 1'b1;
            end else begin
              shift_nxt = shift_nxt + SHIFT_W'(7);
              // A continuation bit on the tenth byte is an overflow.
              if (shift_nxt > LAST_BIT) begin
                ok_nxt = 1'b0;
                done   = 1'b1;
              end
            end
          end
          OP_SLEB: begin
            acc_nxt   = acc_nxt | (low7_ext << shift_nxt[5:0]);
            shift_nxt = shift_nxt + SHIFT_W'(7);
            if (shift_nxt > LAST_BIT || (item.data_byte & CONT_MASK) == 8'h00) begin
              done = 1'b1;
              // Sign-extend only while the shift still lies inside the word.
              if (shift_nxt <= LAST_BIT && (item.data_byte & SIGN_MASK) != 8'h00) begin
                acc_nxt = acc_nxt | ({VALUE_W{1'b1}} << shift_nxt[5:0]);
              end
            end
            value = acc_nxt;
          end
          OP_STRING: begin
            // The NUL ends the string; other bytes count its length.
            if (item.data_byte == 8'h00) begin
              done = 1'b1;
            end else begin
              acc_nxt = acc_nxt + VALUE_W'(1);
            end
            value = acc_nxt;
          end
          default: begin
            in_field_nxt = 1'b0;
          end
        endcase
      end

      if (done) begin
        in_field_nxt = 1'b0;
      end
    end
  end

  // Result fields of a finished field.
  assign res_valid       = step && done;
  assign res.field_value = value;
  assign res.all_ok      = ok_nxt;
  assign res.field_start = COUNT_W'(start_nxt);
  assign res.bytes_used  = COUNT_W'(cursor_nxt - start_nxt);

  // Field state, updated once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= OP_U8;
      in_field_r <= 1'b0;
      acc_r      <= '0;
      shift_r    <= '0;
      ok_r       <= 1'b1;
      cursor_r   <= '0;
      start_r    <= '0;
    end else if (step) begin
      kind_r     <= kind_nxt;
      in_field_r <= in_field_nxt;
      acc_r      <= acc_nxt;
      shift_r    <= shift_nxt;
      ok_r       <= ok_nxt;
      cursor_r   <= cursor_nxt;
      start_r    <= start_nxt;
    end
  end

endmodule : lfr_decode

`default_nettype wire

FILE: src/leb128_and_le_field_reader_top.sv
// A byte accepted into the input register is decoded when it moves on, which it does
// whenever the result register can take a result; a result it ends is registered there.
// Throughput: one byte per cycle, set by the single decode step between the
// input register and the result register; a held result stalls the input
// once the input register is also full.
// Reset: synchronous, active low; clears both registers' valid flags, the
// field state, the cursor, and sets the ok flag.
// Top level: input register, field decoder and result register.
// Depends on lfr_pkg and lfr_decode.
`timescale 1ns / 1ps
`default_nettype none

module leb128_and_le_field_reader_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lfr_pkg::IN_TDATA_W-1:0]    in_tdata,  // [7:0] data_byte
  input  wire logic [lfr_pkg::IN_TUSER_W-1:0]    in_tuser,  // [2:0] opcode, [3] buffer_exhausted
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lfr_pkg::OUT_TDATA_W-1:0]        out_tdata, // [63:0] field_value,
                                                            // [95:64] field_start,
                                                            // [127:96] bytes_used
  output logic [lfr_pkg::OUT_TUSER_W-1:0]        out_tuser  // [0] all_ok
);
  import lfr_pkg::*;

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance;
  logic    res_valid;
  result_t res;

  // The held item moves on whenever the result register can take a result.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.opcode           <= op_t'(in_tuser[2:0]);
      in_item_r.buffer_exhausted <= in_tuser[3];
      in_item_r.data_byte        <= in_tdata[7:0];
    end
  end

  lfr_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (in_item_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.bytes_used, out_res_r.field_start, out_res_r.field_value};
  assign out_tuser  = out_res_r.all_ok;

endmodule : leb128_and_le_field_reader_top

`default_nettype wire

FILE: src/lfr_checker.sv
// Port-level checker for the field reader, bound to the top level.
// Depends on lfr_pkg and leb128_and_le_field_reader_top.
`timescale 1ns / 1ps
`default_nettype none

module lfr_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [lfr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input wire logic [lfr_pkg::IN_TUSER_W-1:0]    in_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [lfr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic [lfr_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import lfr_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The input side only stalls behind a result that is itself stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // A new result follows an item accepted earlier, with the input register between them.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching item");

endmodule : lfr_checker

bind leb128_and_le_field_reader_top lfr_checker u_lfr_checker (.*);

`default_nettype wire
